@@ sv/lgst_pkg.sv @@
// shared types and constants for the toroidal life generation block
// no dependencies; imported by lgst_row and the top level (lgst_ram is standalone)
package lgst_pkg;

	// grid geometry
	localparam int GRID_WIDTH  = 32;
	localparam int GRID_HEIGHT = 32;

	// item field width and derived index widths
	localparam int FIELD_W = 5;
	localparam int COL_W   = $clog2(GRID_WIDTH);
	localparam int ROW_W   = $clog2(GRID_HEIGHT);
	localparam int POS_W   = $clog2(GRID_HEIGHT + 2);

	// b3/s23 neighbor counts
	localparam logic [3:0] BIRTH_CNT   = 4'd3;
	localparam logic [3:0] SURVIVE_CNT = 4'd2;

	typedef enum logic [1:0] {
		FN_SET   = 2'd0,
		FN_CLEAR = 2'd1,
		FN_STEP  = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [FIELD_W-1:0] col;
		logic [FIELD_W-1:0] row;
	} cmd_t;

	typedef struct packed {
		logic alive;
		logic was_alive;
		logic step_done;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_COPY,
		ST_FLUSH,
		ST_GEN,
		ST_TAIL
	} state_t;

endpackage

@@ sv/lgst_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// standalone, no package dependencies
module lgst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/lgst_row.sv @@
// next-generation evaluation of one grid row from three previous-generation rows
// depends on lgst_pkg for grid width and the b3/s23 counts
module lgst_row
	import lgst_pkg::*;
(
	input  logic [GRID_WIDTH-1:0] up,
	input  logic [GRID_WIDTH-1:0] mid,
	input  logic [GRID_WIDTH-1:0] dn,
	output logic [GRID_WIDTH-1:0] nxt
);

	// one neighbor counter per column, columns wrap around
	for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
		localparam int CL = (c + GRID_WIDTH - 1) % GRID_WIDTH;
		localparam int CR = (c + 1) % GRID_WIDTH;
		logic [3:0] n;

		assign n = 4'(up[CL]) + 4'(up[c]) + 4'(up[CR])
			+ 4'(mid[CL]) + 4'(mid[CR])
			+ 4'(dn[CL]) + 4'(dn[c]) + 4'(dn[CR]);

		// born with three, survives with two or three
		assign nxt[c] = (n == BIRTH_CNT) || (mid[c] && (n == SURVIVE_CNT));
	end

endmodule

@@ sv/life_generation_step_torus.sv @@
// top level of the toroidal life block: command fsm, row stores, generation sweep
// depends on lgst_pkg, lgst_ram and lgst_row
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------------
//  command  | start, busy, cmd       | item taken at a clock edge with start & !busy
//  response | done, rsp              | one-cycle strobe on done, cannot be held off
//
// set, clear and read go through a row read, then modify/write; the response
// shows in the cycle after, while busy is already low.
// a step keeps busy high through the copy, flush, sweep and tail states (one
// row per cycle through the single read port of each store, first copying current
// rows to previous, then the sweep); its response shows in the cycle after.
// reset clears one valid bit per row of each store; an invalid row reads as dead.
// no clearing pass after reset; items are taken from the first cycle.
module life_generation_step_torus
	import lgst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	state_t state_q, state_d;

	logic [POS_W-1:0] rc_q;
	func_t            func_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [GRID_HEIGHT-1:0] cur_vld_q, prev_vld_q;
	logic                   cur_rv_s1, prev_rv_s1;

	logic                  gen_s1, copy_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [ROW_W-1:0]      copy_addr_s1;
	logic [GRID_WIDTH-1:0] up_q, mid_q;

	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic [COL_W-1:0]      col_w;
	logic [ROW_W-1:0]      row_w;

	logic                  cur_wr_en, cur_rd_en, prev_wr_en, prev_rd_en;
	logic [ROW_W-1:0]      cur_wr_addr, cur_rd_addr, prev_wr_addr, prev_rd_addr;
	logic [GRID_WIDTH-1:0] cur_wr_data, cur_rd_data, prev_rd_data;
	logic [GRID_WIDTH-1:0] cur_row, prev_row, cell_row, gen_row;
	logic                  gen_wr;
	logic [ROW_W-1:0]      gen_rd_addr;

	// address wrap onto the torus
	assign col_w  = COL_W'(32'(cmd.col) % GRID_WIDTH);
	assign row_w  = ROW_W'(32'(cmd.row) % GRID_HEIGHT);
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// rows not yet written read as all dead
	assign cur_row  = cur_rd_data & {GRID_WIDTH{cur_rv_s1}};
	assign prev_row = prev_rd_data & {GRID_WIDTH{prev_rv_s1}};

	// cell update of the addressed row
	always_comb begin
		cell_row = cur_row;
		if (func_q == FN_SET) begin
			cell_row[col_q] = 1'b1;
		end else if (func_q == FN_CLEAR) begin
			cell_row[col_q] = 1'b0;
		end
	end

	// sweep read order: last row, then all rows, then first row again
	always_comb begin
		if (rc_q == '0) begin
			gen_rd_addr = ROW_W'(GRID_HEIGHT - 1);
		end else if (rc_q == POS_W'(GRID_HEIGHT + 1)) begin
			gen_rd_addr = '0;
		end else begin
			gen_rd_addr = ROW_W'(rc_q - POS_W'(1));
		end
	end

	// a new row is due once three window rows are present
	assign gen_wr = gen_s1 && (pos_s1 >= POS_W'(2));

	lgst_row u_row (
		.up  (up_q),
		.mid (mid_q),
		.dn  (prev_row),
		.nxt (gen_row)
	);

	// next state and store control
	always_comb begin
		state_d      = state_q;
		cur_rd_en    = 1'b0;
		cur_rd_addr  = row_w;
		prev_rd_en   = 1'b0;
		prev_rd_addr = row_w;
		cur_wr_en    = 1'b0;
		cur_wr_addr  = row_q;
		cur_wr_data  = cell_row;
		prev_wr_en   = copy_s1;
		prev_wr_addr = copy_addr_s1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.func == FN_STEP) begin
						state_d = ST_COPY;
					end else begin
						state_d    = ST_CELL;
						cur_rd_en  = 1'b1;
						prev_rd_en = 1'b1;
					end
				end
			end
			ST_CELL: begin
				cur_wr_en = (func_q == FN_SET) || (func_q == FN_CLEAR);
				state_d   = ST_IDLE;
			end
			ST_COPY: begin
				cur_rd_en   = 1'b1;
				cur_rd_addr = rc_q[ROW_W-1:0];
				if (rc_q == POS_W'(GRID_HEIGHT - 1)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// last previous row is being written, keep its read for next cycle
				state_d = ST_GEN;
			end
			ST_GEN: begin
				prev_rd_en   = 1'b1;
				prev_rd_addr = gen_rd_addr;
				if (rc_q == POS_W'(GRID_HEIGHT + 1)) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (gen_wr) begin
			cur_wr_en   = 1'b1;
			cur_wr_addr = ROW_W'(pos_s1 - POS_W'(2));
			cur_wr_data = gen_row;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
		end else if ((state_q == ST_COPY || state_q == ST_GEN) && state_d == state_q) begin
			rc_q <= rc_q + POS_W'(1);
		end else begin
			rc_q <= '0;
		end
	end

	// row valid bits and read-side pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q  <= '0;
			prev_vld_q <= '0;
			gen_s1     <= 1'b0;
			copy_s1    <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cur_wr_en) begin
				cur_vld_q[cur_wr_addr] <= 1'b1;
			end
			if (prev_wr_en) begin
				prev_vld_q[prev_wr_addr] <= 1'b1;
			end
			gen_s1  <= (state_q == ST_GEN);
			copy_s1 <= (state_q == ST_COPY);
			done_q  <= (state_q == ST_CELL) || (state_q == ST_TAIL);
		end
	end

	// item fields, read flags, window rows and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			col_q  <= col_w;
			row_q  <= row_w;
		end
		cur_rv_s1    <= cur_vld_q[cur_rd_addr];
		prev_rv_s1   <= prev_vld_q[prev_rd_addr];
		pos_s1       <= rc_q;
		copy_addr_s1 <= rc_q[ROW_W-1:0];
		if (gen_s1) begin
			up_q  <= mid_q;
			mid_q <= prev_row;
		end
		if (state_q == ST_CELL) begin
			rsp_q.alive     <= cell_row[col_q];
			rsp_q.was_alive <= prev_row[col_q];
			rsp_q.step_done <= 1'b0;
		end else if (state_q == ST_TAIL) begin
			rsp_q.alive     <= 1'b0;
			rsp_q.was_alive <= 1'b0;
			rsp_q.step_done <= 1'b1;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	lgst_ram #(
		.WIDTH (GRID_WIDTH),
		.DEPTH (GRID_HEIGHT)
	) u_cur_ram (
		.clk     (clk),
		.wr_en   (cur_wr_en),
		.wr_addr (cur_wr_addr),
		.wr_data (cur_wr_data),
		.rd_en   (cur_rd_en),
		.rd_addr (cur_rd_addr),
		.rd_data (cur_rd_data)
	);

	// previous rows are only ever the copy of the current rows
	lgst_ram #(
		.WIDTH (GRID_WIDTH),
		.DEPTH (GRID_HEIGHT)
	) u_prev_ram (
		.clk     (clk),
		.wr_en   (prev_wr_en),
		.wr_addr (prev_wr_addr),
		.wr_data (cur_row),
		.rd_en   (prev_rd_en),
		.rd_addr (prev_rd_addr),
		.rd_data (prev_rd_data)
	);

`ifndef SYNTHESIS
	// a response only follows a cell access or the end of a sweep
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_CELL || state_q == ST_TAIL))
		else $error("response without a finished item");

	// no read of a previous row while it is being written
	a_prev_rw: assert property (@(posedge clk) disable iff (!arst_n)
		prev_wr_en && prev_rd_en |-> prev_wr_addr != prev_rd_addr)
		else $error("previous row read during its write");

	// the sweep only starts once every previous row holds the copy
	a_gen_vld: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN |-> &prev_vld_q)
		else $error("sweep over unwritten previous rows");

	// step responses carry no cell bits
	a_step_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.step_done |-> !rsp.alive && !rsp.was_alive)
		else $error("step response with cell bits");

	// an accepted item keeps the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted without going busy");
`endif

endmodule
